@@ hw/rtl/sle_pkg.sv @@
// ----------------------------------------------------------------------------
// sle_pkg: shared types and constants for the scancode line editor
// Holds the controller states, the result kinds, the key codes and the
// set-1 scancode to ASCII translation (Latin layout).
// ----------------------------------------------------------------------------
package sle_pkg;

    localparam int CHAR_W  = 7;   // ASCII character width
    localparam int COUNT_W = 7;   // fill count and line position width
    localparam int CODE_W  = 8;   // raw scancode width
    localparam int KIND_W  = 2;   // result kind width

    localparam logic [CODE_W-1:0] KEY_BACKSPACE = 8'h0E;
    localparam logic [CODE_W-1:0] KEY_ENTER     = 8'h1C;
    localparam int                KEY_RELEASE_BIT = 7;

    typedef enum logic [KIND_W-1:0] {
        EV_ECHO      = 2'd0,
        EV_ERASE     = 2'd1,
        EV_LINE_CHAR = 2'd2,
        EV_EMPTY     = 2'd3
    } ev_kind_t;

    typedef enum logic {
        ST_IDLE  = 1'b0,
        ST_DRAIN = 1'b1
    } state_t;

    // Make-code to ASCII; zero means the key has no character.
    function automatic logic [CHAR_W-1:0] key_map(input logic [6:0] code);
        logic [CHAR_W-1:0] ch;
        unique case (code)
            7'h02: ch = 7'h31;  // 1
            7'h03: ch = 7'h32;  // 2
            7'h04: ch = 7'h33;  // 3
            7'h05: ch = 7'h34;  // 4
            7'h06: ch = 7'h35;  // 5
            7'h07: ch = 7'h36;  // 6
            7'h08: ch = 7'h37;  // 7
            7'h09: ch = 7'h38;  // 8
            7'h0A: ch = 7'h39;  // 9
            7'h0B: ch = 7'h30;  // 0
            7'h0C: ch = 7'h2D;  // -
            7'h0D: ch = 7'h3D;  // =
            7'h10: ch = 7'h71;  // q
            7'h11: ch = 7'h77;  // w
            7'h12: ch = 7'h65;  // e
            7'h13: ch = 7'h72;  // r
            7'h14: ch = 7'h74;  // t
            7'h15: ch = 7'h79;  // y
            7'h16: ch = 7'h75;  // u
            7'h17: ch = 7'h69;  // i
            7'h18: ch = 7'h6F;  // o
            7'h19: ch = 7'h70;  // p
            7'h1A: ch = 7'h27;  // apostrophe
            7'h1B: ch = 7'h2B;  // +
            7'h1E: ch = 7'h61;  // a
            7'h1F: ch = 7'h73;  // s
            7'h20: ch = 7'h64;  // d
            7'h21: ch = 7'h66;  // f
            7'h22: ch = 7'h67;  // g
            7'h23: ch = 7'h68;  // h
            7'h24: ch = 7'h6A;  // j
            7'h25: ch = 7'h6B;  // k
            7'h26: ch = 7'h6C;  // l
            7'h27: ch = 7'h6E;  // n
            7'h28: ch = 7'h7B;  // {
            7'h2B: ch = 7'h7D;  // }
            7'h2C: ch = 7'h7A;  // z
            7'h2D: ch = 7'h78;  // x
            7'h2E: ch = 7'h63;  // c
            7'h2F: ch = 7'h76;  // v
            7'h30: ch = 7'h62;  // b
            7'h31: ch = 7'h6E;  // n
            7'h32: ch = 7'h6D;  // m
            7'h33: ch = 7'h2C;  // ,
            7'h34: ch = 7'h2E;  // .
            7'h35: ch = 7'h2D;  // -
            7'h39: ch = 7'h20;  // space
            default: ch = '0;
        endcase
        return ch;
    endfunction

endpackage

@@ hw/rtl/sle_ram.sv @@
// ----------------------------------------------------------------------------
// sle_ram: generic single-write, single-read RAM
// One write port and one read port; the read data is registered and holds
// until the next read.
// ----------------------------------------------------------------------------
module sle_ram #(
    parameter int WIDTH = 7,
    parameter int DEPTH = 64
) (
    input  logic                                 aclk,
    input  logic                                 wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                     wr_data,
    input  logic                                 rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                     rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ hw/rtl/scancode_line_editor_top.sv @@
// ----------------------------------------------------------------------------
// scancode_line_editor_top: set-1 scancode line editor
// Takes one keyboard scancode per word on the slave stream. Key releases,
// unmapped keys, Backspace on an empty line and printable keys on a full
// line give no word. A printable key is stored and echoed, Backspace drops
// the last character and reports the new length, and Enter sends the held
// line out one character per word with tlast on the final one (or a single
// empty-line word) and clears the line. Every key other than a non-empty
// Enter is accepted back to back while the result register is free or
// being taken. A non-empty Enter holds the input off while the line is
// sent at full output rate whenever the output is taken: the line store
// is one synchronous RAM with a registered read, read once per emitted
// character. The line store needs no clearing pass after reset; only
// entries below the fill count are ever read.
// ----------------------------------------------------------------------------
module scancode_line_editor_top #(
    parameter int MAX_LINE = 64        // line capacity, 1 to 127
) (
    input  logic        aclk,
    input  logic        aresetn,
    // slave stream: scancodes
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,       // [7:0] scan_code
    // master stream: editor events
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,       // [6:0] ascii_char, [13:7] line_length, [15:14] zero
    output logic [1:0]  m_tuser,       // [1:0] event_kind
    output logic        m_tlast        // last_of_line
);

    localparam int ADDR_W = (MAX_LINE > 1) ? $clog2(MAX_LINE) : 1;
    localparam logic [sle_pkg::COUNT_W-1:0] MAX_FILL = sle_pkg::COUNT_W'(MAX_LINE);

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    sle_pkg::state_t                 state_reg, state_next;
    logic [sle_pkg::COUNT_W-1:0]     fill_count_reg, fill_count_next;
    logic [sle_pkg::COUNT_W-1:0]     drain_len_reg, drain_len_next;
    logic [sle_pkg::COUNT_W-1:0]     drain_idx_reg, drain_idx_next;

    // result register
    logic                            m_valid_reg, m_valid_next;
    sle_pkg::ev_kind_t               m_kind_reg;
    logic [sle_pkg::CHAR_W-1:0]      m_char_reg;
    logic [sle_pkg::COUNT_W-1:0]     m_len_reg;
    logic                            m_last_reg;

    // result load from the control logic
    logic                            ld_en;
    sle_pkg::ev_kind_t               ld_kind;
    logic [sle_pkg::CHAR_W-1:0]      ld_char;
    logic [sle_pkg::COUNT_W-1:0]     ld_len;
    logic                            ld_last;

    // line store ports
    logic                            ram_we;
    logic                            ram_re;
    logic [sle_pkg::COUNT_W-1:0]     ram_raddr;
    logic [sle_pkg::CHAR_W-1:0]      ram_rdata;

    // ------------------------------------------------------------------
    // Shared decode
    // ------------------------------------------------------------------
    logic                            out_free;
    logic                            in_accept;
    logic                            is_release;
    logic                            is_enter;
    logic                            is_backspace;
    logic [sle_pkg::CHAR_W-1:0]      key_char;
    logic [sle_pkg::COUNT_W-1:0]     drain_idx_inc;
    logic                            drain_last;
    logic                            fill_zero;

    // The result register frees up in the cycle it is taken.
    assign out_free      = !m_valid_reg || m_tready;
    assign in_accept     = s_tvalid && s_tready;
    assign is_release    = s_tdata[sle_pkg::KEY_RELEASE_BIT];
    assign is_enter      = (s_tdata == sle_pkg::KEY_ENTER);
    assign is_backspace  = (s_tdata == sle_pkg::KEY_BACKSPACE);
    assign key_char      = sle_pkg::key_map(s_tdata[6:0]);
    assign drain_idx_inc = drain_idx_reg + 1'b1;
    assign drain_last    = (drain_idx_inc == drain_len_reg);
    assign fill_zero     = (fill_count_reg == '0);

    // ------------------------------------------------------------------
    // Line store
    // ------------------------------------------------------------------
    sle_ram #(
        .WIDTH (sle_pkg::CHAR_W),
        .DEPTH (MAX_LINE)
    ) u_line_store (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (fill_count_reg[ADDR_W-1:0]),
        .wr_data (key_char),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr[ADDR_W-1:0]),
        .rd_data (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            sle_pkg::ST_IDLE: begin
                // enter drain only when there is a line to send
                if (in_accept && is_enter && !fill_zero) begin
                    state_next = sle_pkg::ST_DRAIN;
                end
            end
            sle_pkg::ST_DRAIN: begin
                if (out_free && drain_last) begin
                    state_next = sle_pkg::ST_IDLE;
                end
            end
            default: state_next = sle_pkg::ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Outputs and datapath control
    // ------------------------------------------------------------------
    always_comb begin
        s_tready        = 1'b0;
        ram_we          = 1'b0;
        ram_re          = 1'b0;
        ram_raddr       = drain_idx_inc;
        ld_en           = 1'b0;
        ld_kind         = sle_pkg::EV_ECHO;
        ld_char         = '0;
        ld_len          = '0;
        ld_last         = 1'b0;
        fill_count_next = fill_count_reg;
        drain_len_next  = drain_len_reg;
        drain_idx_next  = drain_idx_reg;

        unique case (state_reg)
            sle_pkg::ST_IDLE: begin
                s_tready = out_free;
                if (s_tvalid && out_free && !is_release) begin
                    priority if (is_enter) begin
                        if (fill_zero) begin
                            ld_en   = 1'b1;
                            ld_kind = sle_pkg::EV_EMPTY;
                            ld_last = 1'b1;
                        end else begin
                            // fetch the first character; it lands next cycle
                            ram_re          = 1'b1;
                            ram_raddr       = '0;
                            drain_len_next  = fill_count_reg;
                            drain_idx_next  = '0;
                            fill_count_next = '0;
                        end
                    end else if (is_backspace) begin
                        if (!fill_zero) begin
                            fill_count_next = fill_count_reg - 1'b1;
                            ld_en   = 1'b1;
                            ld_kind = sle_pkg::EV_ERASE;
                            ld_len  = fill_count_reg - 1'b1;
                        end
                    end else begin
                        if ((key_char != '0) && (fill_count_reg < MAX_FILL)) begin
                            ram_we          = 1'b1;
                            fill_count_next = fill_count_reg + 1'b1;
                            ld_en   = 1'b1;
                            ld_kind = sle_pkg::EV_ECHO;
                            ld_char = key_char;
                            ld_len  = fill_count_reg + 1'b1;
                        end
                    end
                end
            end
            sle_pkg::ST_DRAIN: begin
                // read data holds until the next read, so a stall costs nothing
                if (out_free) begin
                    ld_en   = 1'b1;
                    ld_kind = sle_pkg::EV_LINE_CHAR;
                    ld_char = ram_rdata;
                    ld_len  = drain_idx_reg;
                    ld_last = drain_last;
                    if (!drain_last) begin
                        ram_re         = 1'b1;
                        drain_idx_next = drain_idx_inc;
                    end
                end
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    // hold the result until taken, load a new one when given
    always_comb begin
        priority if (ld_en) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= sle_pkg::ST_IDLE;
            fill_count_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            fill_count_reg <= fill_count_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        drain_len_reg <= drain_len_next;
        drain_idx_reg <= drain_idx_next;
        if (ld_en) begin
            m_kind_reg <= ld_kind;
            m_char_reg <= ld_char;
            m_len_reg  <= ld_len;
            m_last_reg <= ld_last;
        end
    end

    // ------------------------------------------------------------------
    // Master stream
    // ------------------------------------------------------------------
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, m_len_reg, m_char_reg};
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;

endmodule
